// ===== rtl/core/idea_pkg.sv =====
`timescale 1ns / 1ps

package idea_pkg;

    localparam int ROUND_COUNT = 8;
    localparam int NUM_REGS    = 7;
    localparam int NUM_SUBKEYS = 6 * ROUND_COUNT + 4;
    localparam int SK_W        = $clog2(NUM_SUBKEYS);
    localparam int ROUND_W     = $clog2(ROUND_COUNT + 1);
    localparam int KEY_ROT     = 25;

    localparam logic [2:0] REG_CMD   = 3'd0;
    localparam logic [2:0] REG_DATA0 = 3'd1;
    localparam logic [2:0] REG_DATA1 = 3'd2;
    localparam logic [2:0] REG_KEY0  = 3'd3;
    localparam logic [2:0] REG_KEY1  = 3'd4;
    localparam logic [2:0] REG_KEY2  = 3'd5;
    localparam logic [2:0] REG_KEY3  = 3'd6;

    localparam logic [31:0] CMD_ENCRYPT = 32'd1;
    localparam logic [31:0] CMD_DECRYPT = 32'd2;

    // job handed to the engine
    typedef struct packed {
        logic         dec;
        logic [127:0] key;
        logic [63:0]  data;
    } t_job;

    // engine status back to the register front end
    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] data;
    } t_stat;

    // how a decryption subkey is derived from an encryption subkey
    typedef enum logic [1:0] {
        KOP_NONE = 2'd0,
        KOP_AINV = 2'd1,
        KOP_MINV = 2'd2
    } t_kop;

    typedef struct packed {
        logic [SK_W-1:0] idx;
        t_kop            op;
    } t_ksrc;

    // source of decryption subkey (round, k) in the encryption schedule
    function automatic t_ksrc dec_src(input logic [ROUND_W-1:0] rnd, input logic [2:0] k);
        t_ksrc           s;
        logic [SK_W-1:0] b;
        logic [SK_W-1:0] bn;
        logic            first;
        logic            last;
        b     = SK_W'((ROUND_COUNT - int'(rnd)) * 6);
        bn    = b - SK_W'(6);
        first = (rnd == '0);
        last  = (rnd == ROUND_W'(ROUND_COUNT));
        s.idx = b;
        s.op  = KOP_NONE;
        case (k)
            3'd0: begin s.idx = b;               s.op = KOP_MINV; end
            3'd1: begin s.idx = (first || last) ? b + SK_W'(1) : b + SK_W'(2);
                        s.op  = KOP_AINV; end
            3'd2: begin s.idx = (first || last) ? b + SK_W'(2) : b + SK_W'(1);
                        s.op  = KOP_AINV; end
            3'd3: begin s.idx = b + SK_W'(3);    s.op = KOP_MINV; end
            3'd4: begin s.idx = bn + SK_W'(4);   s.op = KOP_NONE; end
            3'd5: begin s.idx = bn + SK_W'(5);   s.op = KOP_NONE; end
            default: begin s.idx = b;            s.op = KOP_NONE; end
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/core/idea_if.sv =====
`timescale 1ns / 1ps

interface idea_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [2:0]  reg_addr;
    logic [31:0] wr_value;

    modport source (output valid, output req_type, output reg_addr, output wr_value,
                    input ready);
    modport sink   (input valid, input req_type, input reg_addr, input wr_value,
                    output ready);
endinterface

interface idea_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] rd_value;

    modport source (output valid, output rd_value, input ready);
    modport sink   (input valid, input rd_value, output ready);
endinterface

// ===== rtl/core/idea_block_cipher_device.sv =====
`timescale 1ns / 1ps
// idea cipher engine behind a seven-register bus (64-bit block, 128-bit key)
// request channel i_req: req_type (0 read, 1 write), reg_addr, wr_value
// response channel o_rsp: rd_value, one item per read, none per write
// registers: 0 command, 1-2 data, 3-6 key low to high; index seven reads zero
// writing 1 (encrypt) or 2 (decrypt) to the command register starts a job
// encrypt: run time is set by four mod-65537 multiplies per round
//   through the single shared multiplier, plus a key fetch per subkey
// decrypt: slower, the 18 multiplicative key inverses each take
//   31 multiplies on the same multiplier
// i_req.ready is low while a job runs; the result lands in data registers
// read response sits in an output register; a stalled receiver holds only
//   further reads and writes, a waiting response never blocks a running job
// reset (synchronous, active low) clears all seven bus registers and aborts any job

module idea_block_cipher_device import idea_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    idea_req_if.sink   i_req,
    idea_rsp_if.source o_rsp
);

    logic [31:0] r_regs [NUM_REGS];
    logic        r_rsp_valid;
    logic [31:0] r_rsp_data;

    t_stat       stat;
    t_job        job;
    logic        req_acc;
    logic        start;
    logic        cmd_run;

    // hold requests during a job and while an unread response is stuck
    assign i_req.ready = !stat.busy && (!r_rsp_valid || o_rsp.ready);
    assign req_acc     = i_req.valid && i_req.ready;

    assign cmd_run = (i_req.wr_value == CMD_ENCRYPT) || (i_req.wr_value == CMD_DECRYPT);
    assign start   = req_acc && i_req.req_type && (i_req.reg_addr == REG_CMD) && cmd_run;

    // job takes the data and key as written in earlier cycles
    assign job.dec  = (i_req.wr_value == CMD_DECRYPT);
    assign job.key  = {r_regs[REG_KEY3], r_regs[REG_KEY2], r_regs[REG_KEY1], r_regs[REG_KEY0]};
    assign job.data = {r_regs[REG_DATA1], r_regs[REG_DATA0]};

    idea_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_job   (job),
        .o_stat  (stat)
    );

    // register file, written by the bus or by the engine at job end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
        end else if (stat.done) begin
            r_regs[REG_DATA0] <= stat.data[31:0];
            r_regs[REG_DATA1] <= stat.data[63:32];
        end else if (req_acc && i_req.req_type && (i_req.reg_addr < 3'(NUM_REGS))) begin
            r_regs[i_req.reg_addr] <= i_req.wr_value;
        end
    end

    // read response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (req_acc && !i_req.req_type) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
        if (req_acc && !i_req.req_type) begin
            r_rsp_data <= (i_req.reg_addr < 3'(NUM_REGS)) ? r_regs[i_req.reg_addr] : 32'd0;
        end
    end

    assign o_rsp.valid    = r_rsp_valid;
    assign o_rsp.rd_value = r_rsp_data;

`ifndef SYNTHESIS
    // no request is taken while a job runs
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.busy |-> !i_req.ready)
        else $error("request accepted during job");

    // a run command starts the engine
    a_cmd_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> stat.busy)
        else $error("command did not start engine");

    // job end returns the engine to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.done |=> !stat.busy)
        else $error("engine busy after job end");

    // a write never yields a response
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && i_req.req_type && !r_rsp_valid) |=> !r_rsp_valid)
        else $error("response after write");
`endif

endmodule

// ===== rtl/core/idea_mulmod.sv =====
`timescale 1ns / 1ps

module idea_mulmod import idea_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_a,
    input  logic [15:0] i_b,
    output logic        o_done,
    output logic [15:0] o_res
);

    logic [33:0] r_prod;
    logic        r_v1;
    logic        r_done;
    logic [15:0] r_res;
    logic [16:0] x;
    logic [16:0] y;
    logic [17:0] lo;
    logic [17:0] hi;
    logic [17:0] red;

    // zero operand stands for 2^16
    assign x = (i_a == 16'd0) ? 17'h10000 : {1'b0, i_a};
    assign y = (i_b == 16'd0) ? 17'h10000 : {1'b0, i_b};

    // 2^16 == -1 mod 65537: p mod 65537 = lo - hi
    assign lo  = {2'b00, r_prod[15:0]};
    assign hi  = r_prod[33:16];
    assign red = (lo >= hi) ? lo - hi : lo + 18'd65537 - hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_done <= r_v1;
        end
        r_prod <= x * y;
        r_res  <= red[15:0];
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== rtl/core/idea_core.sv =====
`timescale 1ns / 1ps

module idea_core import idea_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_job  i_job,
    output t_stat o_stat
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_KEY   = 6'b000010,
        S_INV   = 6'b000100,
        S_APPLY = 6'b001000,
        S_WAIT  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    typedef enum logic [2:0] {
        W_ACC, W_BASE, W_A, W_D, W_P, W_Q
    } t_wsel;

    t_state             r_state, n_state;
    t_wsel              r_wsel, n_wsel;
    logic               r_dec, n_dec;
    logic [127:0]       r_key, n_key;
    logic [15:0]        r_x1, n_x1, r_x2, n_x2, r_x3, n_x3, r_x4, n_x4;
    logic [15:0]        r_a, n_a, r_b, n_b, r_c, n_c, r_d, n_d, r_p, n_p;
    logic [15:0]        r_kv, n_kv, r_acc, n_acc, r_base, n_base;
    logic               r_inv_ph, n_inv_ph;
    logic [3:0]         r_cnt, n_cnt;
    logic [ROUND_W-1:0] r_round, n_round;
    logic [2:0]         r_k, n_k;

    logic               m_start;
    logic [15:0]        m_a, m_b;
    logic               m_done;
    logic [15:0]        m_res;

    logic               last_rnd;
    logic [SK_W-1:0]    j_idx;
    t_ksrc              src;
    logic [15:0]        ev;
    logic [15:0]        m_sum;

    // subkey idx of the encryption schedule: key rotated left 25 per group of eight
    function automatic logic [15:0] key_word(input logic [127:0] key,
                                             input logic [SK_W-1:0] idx);
        logic [7:0]   g25;
        logic [6:0]   off;
        logic [255:0] dbl;
        g25 = 8'(idx[SK_W-1:3]) * 8'(KEY_ROT);
        off = {idx[2:0], 4'b0000} + g25[6:0];
        dbl = {key, key} << off;
        return dbl[255:240];
    endfunction

    idea_mulmod u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (m_start),
        .i_a     (m_a),
        .i_b     (m_b),
        .o_done  (m_done),
        .o_res   (m_res)
    );

    assign last_rnd = (r_round == ROUND_W'(ROUND_COUNT));
    assign j_idx    = SK_W'(r_round) * SK_W'(6) + SK_W'(r_k);
    assign src      = dec_src(r_round, r_k);
    assign ev       = key_word(r_key, r_dec ? src.idx : j_idx);
    assign m_sum    = r_p + m_res;

    always_comb begin
        n_state  = r_state;
        n_wsel   = r_wsel;
        n_dec    = r_dec;
        n_key    = r_key;
        n_x1     = r_x1;
        n_x2     = r_x2;
        n_x3     = r_x3;
        n_x4     = r_x4;
        n_a      = r_a;
        n_b      = r_b;
        n_c      = r_c;
        n_d      = r_d;
        n_p      = r_p;
        n_kv     = r_kv;
        n_acc    = r_acc;
        n_base   = r_base;
        n_inv_ph = r_inv_ph;
        n_cnt    = r_cnt;
        n_round  = r_round;
        n_k      = r_k;
        m_start  = 1'b0;
        m_a      = r_acc;
        m_b      = r_base;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_dec   = i_job.dec;
                    n_key   = i_job.key;
                    n_x1    = i_job.data[15:0];
                    n_x2    = i_job.data[31:16];
                    n_x3    = i_job.data[47:32];
                    n_x4    = i_job.data[63:48];
                    n_round = '0;
                    n_k     = '0;
                    n_state = S_KEY;
                end
            end
            S_KEY: begin
                n_state = S_APPLY;
                if (!r_dec) begin
                    n_kv = ev;
                end else begin
                    case (src.op)
                        KOP_AINV: n_kv = 16'd0 - ev;
                        KOP_MINV: begin
                            n_base   = ev;
                            n_acc    = 16'd1;
                            n_cnt    = '0;
                            n_inv_ph = 1'b0;
                            n_state  = S_INV;
                        end
                        default:  n_kv = ev;
                    endcase
                end
            end
            S_INV: begin
                // x^65535 by square and multiply, all sixteen exponent bits set
                m_start = 1'b1;
                m_a     = r_inv_ph ? r_base : r_acc;
                m_b     = r_base;
                n_wsel  = r_inv_ph ? W_BASE : W_ACC;
                n_state = S_WAIT;
            end
            S_APPLY: begin
                case (r_k)
                    3'd0: begin
                        m_start = 1'b1; m_a = r_x1; m_b = r_kv;
                        n_wsel = W_A; n_state = S_WAIT;
                    end
                    3'd1: begin
                        n_b = (last_rnd ? r_x3 : r_x2) + r_kv;
                        n_k = r_k + 3'd1; n_state = S_KEY;
                    end
                    3'd2: begin
                        n_c = (last_rnd ? r_x2 : r_x3) + r_kv;
                        n_k = r_k + 3'd1; n_state = S_KEY;
                    end
                    3'd3: begin
                        m_start = 1'b1; m_a = r_x4; m_b = r_kv;
                        n_wsel = W_D; n_state = S_WAIT;
                    end
                    3'd4: begin
                        m_start = 1'b1; m_a = r_a ^ r_c; m_b = r_kv;
                        n_wsel = W_P; n_state = S_WAIT;
                    end
                    default: begin
                        m_start = 1'b1; m_a = r_p + (r_b ^ r_d); m_b = r_kv;
                        n_wsel = W_Q; n_state = S_WAIT;
                    end
                endcase
            end
            S_WAIT: begin
                if (m_done) begin
                    n_state = S_KEY;
                    case (r_wsel)
                        W_ACC: begin
                            n_acc    = m_res;
                            n_inv_ph = 1'b1;
                            if (r_cnt == 4'd15) begin
                                n_kv    = m_res;
                                n_state = S_APPLY;
                            end else begin
                                n_state = S_INV;
                            end
                        end
                        W_BASE: begin
                            n_base   = m_res;
                            n_inv_ph = 1'b0;
                            n_cnt    = r_cnt + 4'd1;
                            n_state  = S_INV;
                        end
                        W_A: begin
                            n_a = m_res;
                            n_k = r_k + 3'd1;
                        end
                        W_D: begin
                            n_d = m_res;
                            if (last_rnd) begin
                                n_state = S_DONE;
                            end else begin
                                n_k = r_k + 3'd1;
                            end
                        end
                        W_P: begin
                            n_p = m_res;
                            n_k = r_k + 3'd1;
                        end
                        default: begin
                            n_x1    = r_a ^ m_res;
                            n_x2    = r_c ^ m_res;
                            n_x3    = r_b ^ m_sum;
                            n_x4    = r_d ^ m_sum;
                            n_k     = '0;
                            n_round = r_round + ROUND_W'(1);
                        end
                    endcase
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_wsel   <= n_wsel;
        r_dec    <= n_dec;
        r_key    <= n_key;
        r_x1     <= n_x1;
        r_x2     <= n_x2;
        r_x3     <= n_x3;
        r_x4     <= n_x4;
        r_a      <= n_a;
        r_b      <= n_b;
        r_c      <= n_c;
        r_d      <= n_d;
        r_p      <= n_p;
        r_kv     <= n_kv;
        r_acc    <= n_acc;
        r_base   <= n_base;
        r_inv_ph <= n_inv_ph;
        r_cnt    <= n_cnt;
        r_round  <= n_round;
        r_k      <= n_k;
    end

    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.done = (r_state == S_DONE);
    assign o_stat.data = {r_d, r_c, r_b, r_a};

endmodule
